[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the occupancy grid RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[rtl/ogcu_pkg.sv]
// ---------------------------------------------------------------------------
// ogcu_pkg
// Types, sizes and codes of the occupancy grid cell update block.
// ---------------------------------------------------------------------------
package ogcu_pkg;

    localparam int GRID_ROWS = 256;
    localparam int GRID_COLS = 256;

    localparam int IDX_W     = 8;
    localparam int IDX_SPAN  = 1 << IDX_W;
    localparam int KEPT_ROWS = (GRID_ROWS < IDX_SPAN) ? GRID_ROWS : IDX_SPAN;
    localparam int KEPT_COLS = (GRID_COLS < IDX_SPAN) ? GRID_COLS : IDX_SPAN;
    localparam int MEM_DEPTH = KEPT_ROWS * KEPT_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int VAL_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [VAL_W-1:0] t_q88;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT  = 2'd2;

    localparam t_q88 UPPER_RST = 16'sd256;
    localparam t_q88 LOWER_RST = -16'sd256;
    localparam t_q88 PROT_RST  = 16'sh8000;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_PROT  = 2'd2
    } t_status;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_init_state;

    typedef struct packed {
        t_q88 upper;
        t_q88 lower;
        t_q88 prot;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_q88              data;
    } t_mem_wr;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        int lin;
        lin = int'(row) * KEPT_COLS + int'(col);
        return lin[ADDR_W-1:0];
    endfunction

    function automatic logic in_grid(input logic [IDX_W-1:0] row,
                                     input logic [IDX_W-1:0] col);
        logic [IDX_W:0] kr;
        logic [IDX_W:0] kc;
        kr = (IDX_W+1)'(KEPT_ROWS);
        kc = (IDX_W+1)'(KEPT_COLS);
        return ({1'b0, row} < kr) && ({1'b0, col} < kc);
    endfunction

endpackage

[rtl/occupancy_grid_cell_update.sv]
// Pipeline: an accepted input passes the stage-1 register and then the result register.
// Throughput: one item per cycle while the result register is free or being read out,
// using the read-modify-write of the cell RAM with forwarding of the previous write.
// Reset: synchronous; clamps return to 256 / -256, protected to -32768, then
// a clearing pass over all KEPT_ROWS*KEPT_COLS (65536) cells zeroes the grid with
// input ready held low. Configuration writes are taken during the pass.
// ---------------------------------------------------------------------------
// occupancy_grid_cell_update
// Saturating Q8.8 occupancy grid held in one synchronous RAM.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module occupancy_grid_cell_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ogcu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ogcu_pkg::VAL_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [ogcu_pkg::IDX_W-1:0]        i_row_index,
    input  logic [ogcu_pkg::IDX_W-1:0]        i_col_index,
    input  logic signed [ogcu_pkg::VAL_W-1:0] i_delta,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [ogcu_pkg::VAL_W-1:0] o_cell_value,
    output logic                              o_written,
    output logic [1:0]                        o_status
);
    import ogcu_pkg::*;

    t_cfg              cfg;
    t_mem_wr           init_wr;
    t_mem_wr           rmw_wr;
    t_mem_wr           mem_wr;
    t_mem_rd           mem_rd;
    logic              run;
    logic [VAL_W-1:0]  rdata;

    ogcu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ogcu_init u_init (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (init_wr),
        .o_run   (run)
    );

    ogcu_rmw u_rmw (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_run        (run),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_delta      (i_delta),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_value (o_cell_value),
        .o_written    (o_written),
        .o_status     (o_status),
        .o_rd         (mem_rd),
        .i_rdata      (rdata),
        .o_wr         (rmw_wr)
    );

    assign mem_wr = run ? rmw_wr : init_wr;

    ogcu_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_wr.we),
        .i_waddr (mem_wr.addr),
        .i_wdata (mem_wr.data),
        .i_re    (mem_rd.re),
        .i_raddr (mem_rd.addr),
        .o_rdata (rdata)
    );

    `ASSERT_NEVER(a_no_xfer_in_clear, i_clk, i_rst_n, i_in_valid && o_in_ready && !run)

endmodule

[rtl/ogcu_ram.sv]
// ---------------------------------------------------------------------------
// ogcu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ogcu_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-during-write returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ogcu_cfg.sv]
// ---------------------------------------------------------------------------
// ogcu_cfg
// Clamp and protected-value registers behind the configuration write port.
// ---------------------------------------------------------------------------
module ogcu_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ogcu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ogcu_pkg::VAL_W-1:0]          i_cfg_data,
    output ogcu_pkg::t_cfg                      o_cfg
);
    import ogcu_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper <= UPPER_RST;
            r_cfg.lower <= LOWER_RST;
            r_cfg.prot  <= PROT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UPPER: r_cfg.upper <= i_cfg_data;
                CFG_LOWER: r_cfg.lower <= i_cfg_data;
                CFG_PROT:  r_cfg.prot  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

[rtl/ogcu_init.sv]
// ---------------------------------------------------------------------------
// ogcu_init
// Post-reset sweep that zeroes every grid cell, one entry per cycle.
// ---------------------------------------------------------------------------
module ogcu_init (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output ogcu_pkg::t_mem_wr o_wr,
    output logic              o_run
);
    import ogcu_pkg::*;

    t_init_state       r_state;
    t_init_state       n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        o_wr.we   = 1'b0;
        o_wr.addr = r_addr;
        o_wr.data = '0;
        o_run     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_wr.we = 1'b1;
                n_addr  = r_addr + 1'b1;
                if (r_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_run = 1'b1;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/ogcu_rmw.sv]
// ---------------------------------------------------------------------------
// ogcu_rmw
// Read-modify-write pipeline: read issue, clamp/write-back with forwarding
// of the last write, and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ogcu_rmw (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ogcu_pkg::t_cfg                i_cfg,
    input  logic                          i_run,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [ogcu_pkg::IDX_W-1:0]    i_row_index,
    input  logic [ogcu_pkg::IDX_W-1:0]    i_col_index,
    input  logic signed [ogcu_pkg::VAL_W-1:0] i_delta,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [ogcu_pkg::VAL_W-1:0] o_cell_value,
    output logic                          o_written,
    output logic [1:0]                    o_status,
    output ogcu_pkg::t_mem_rd             o_rd,
    input  logic [ogcu_pkg::VAL_W-1:0]    i_rdata,
    output ogcu_pkg::t_mem_wr             o_wr
);
    import ogcu_pkg::*;

    // stage 1: item waiting on read data
    logic              r_s1_valid;
    logic              r_s1_op;
    logic              r_s1_in_grid;
    logic              r_s1_edge;
    logic [ADDR_W-1:0] r_s1_addr;
    t_q88              r_s1_delta;

    // last write-back, forwarded when the next item's read overlaps it
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr;
    t_q88              r_wb_data;

    logic              r_out_valid;
    t_q88              r_out_value;
    logic              r_out_written;
    t_status           r_out_status;

    logic              in_xfer;
    logic              s1_adv;
    t_q88              old_val;
    logic signed [VAL_W:0] sum;
    t_q88              clamped;
    t_q88              res_value;
    logic              res_written;
    t_status           res_status;
    logic              upd_ok;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_run && (!r_s1_valid || s1_adv);
    assign in_xfer    = i_in_valid && o_in_ready;

    assign o_rd.re   = in_xfer;
    assign o_rd.addr = cell_addr(i_row_index, i_col_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_op      <= i_operation;
            r_s1_in_grid <= in_grid(i_row_index, i_col_index);
            r_s1_edge    <= (i_row_index == '0) || (i_col_index == '0);
            r_s1_addr    <= cell_addr(i_row_index, i_col_index);
            r_s1_delta   <= i_delta;
        end
    end

    always_comb begin
        old_val = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : t_q88'(i_rdata);
        sum     = $signed({old_val[VAL_W-1], old_val})
                + $signed({r_s1_delta[VAL_W-1], r_s1_delta});
        if (sum > $signed({i_cfg.upper[VAL_W-1], i_cfg.upper})) begin
            clamped = i_cfg.upper;
        end else if (sum < $signed({i_cfg.lower[VAL_W-1], i_cfg.lower})) begin
            clamped = i_cfg.lower;
        end else begin
            clamped = sum[VAL_W-1:0];
        end

        upd_ok      = 1'b0;
        res_value   = old_val;
        res_written = 1'b0;
        res_status  = STATUS_OK;
        if (!r_s1_in_grid) begin
            res_value  = '0;
            res_status = STATUS_RANGE;
        end else if (r_s1_op == OP_READ) begin
            res_status = STATUS_OK;
        end else if (r_s1_edge) begin
            res_status = STATUS_RANGE;
        end else if (old_val == i_cfg.prot) begin
            res_status = STATUS_PROT;
        end else begin
            upd_ok      = 1'b1;
            res_value   = clamped;
            res_written = (clamped != old_val);
        end
    end

    assign o_wr.we   = s1_adv && upd_ok;
    assign o_wr.addr = r_s1_addr;
    assign o_wr.data = clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (o_wr.we) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr.we) begin
            r_wb_addr <= r_s1_addr;
            r_wb_data <= clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value   <= res_value;
            r_out_written <= res_written;
            r_out_status  <= res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;
    assign o_written    = r_out_written;
    assign o_status     = r_out_status;

    `ASSERT_CLK(a_written_ok, i_clk, i_rst_n, r_out_valid && r_out_written |-> r_out_status == STATUS_OK)
    `ASSERT_CLK(a_wb_tracks, i_clk, i_rst_n, o_wr.we |=> r_wb_valid && r_wb_addr == $past(r_s1_addr))
    `ASSERT_CLK(a_wr_clamped, i_clk, i_rst_n, o_wr.we |-> o_wr.data == i_cfg.upper || o_wr.data == i_cfg.lower || (o_wr.data < i_cfg.upper && o_wr.data > i_cfg.lower))

endmodule
